// ===== hdl/quote_ladder_pricer_macros.svh =====
// ----------------------------------------------------------------------------
// Quote ladder pricer assertion macros
// Concurrent check wrappers, clocked on clk_i and disabled while rst_ni is low.
// They compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUOTE_LADDER_PRICER_MACROS_SVH
`define QUOTE_LADDER_PRICER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define QLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QLP_ASSERT_IMP(lbl, ante, cons, msg)
`define QLP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/qlp_pkg.sv =====
// ----------------------------------------------------------------------------
// Quote ladder pricer package
// Register indexes, reset values, field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package qlp_pkg;

  // default parameter values
  localparam int unsigned MAX_LEVELS_DEF = 16;
  localparam int unsigned PRICE_BITS_DEF = 20;

  // fixed field widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TICK_W     = 12;
  localparam int unsigned QTY_W      = 16;
  localparam int unsigned LCNT_W     = 5;
  localparam int unsigned LVL_IDX_W  = 4;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned PROD_W     = 24;
  localparam int unsigned REM_W      = 12;

  // register reset values
  localparam logic [TICK_W-1:0] TICK_RST       = 12'd1;
  localparam logic [TICK_W-1:0] MIN_SPREAD_RST = 12'd2;
  localparam logic [TICK_W-1:0] LEVEL_STEP_RST = 12'd1;
  localparam logic [LCNT_W-1:0] LEVEL_CNT_RST  = 5'd1;
  localparam logic [QTY_W-1:0]  BASE_QTY_RST   = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK,
    REG_MIN_SPREAD,
    REG_LEVEL_STEP,
    REG_LEVEL_COUNT,
    REG_BASE_QTY
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_MUL_MS,
    ST_MS_SEL,
    ST_SPACE,
    ST_ONE_SIDE,
    ST_MID,
    ST_MAG,
    ST_SK1,
    ST_SK2,
    ST_SK3,
    ST_SK4,
    ST_SK5,
    ST_SKEW_T,
    ST_RES,
    ST_HALF,
    ST_WIDTH,
    ST_WCMP,
    ST_PB_LO,
    ST_PB_SEL,
    ST_PA_HI,
    ST_PA_SEL,
    ST_CLAMP_B,
    ST_CLAMP_A,
    ST_PRECHK,
    ST_DIV_B,
    ST_FIX_B,
    ST_DIV_A,
    ST_FIX_A1,
    ST_FIX_A2,
    ST_CHECK,
    ST_NEXT_B,
    ST_NEXT_A,
    ST_EMIT
  } qlp_state_e;

endpackage

// ===== hdl/quote_ladder_pricer.sv =====
// ----------------------------------------------------------------------------
// Quote ladder pricer: inventory-skewed bid/ask ladder from a book snapshot.
// Built around the single shared add/compare unit and its bit-serial tick
// remainder loop. One snapshot at a time: input is not ready until the ladder
// is done; each further ladder level steps through NEXT_B, NEXT_A and EMIT.
// Reset: async active low; config returns to its defaults, sequencer to idle.
// ----------------------------------------------------------------------------
`include "quote_ladder_pricer_macros.svh"

module quote_ladder_pricer #(
  parameter int unsigned MAX_LEVELS = qlp_pkg::MAX_LEVELS_DEF,
  parameter int unsigned PRICE_BITS = qlp_pkg::PRICE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [qlp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [qlp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  // snapshot input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [PRICE_BITS-1:0]                best_bid_i,
  input  logic [PRICE_BITS-1:0]                best_ask_i,
  input  logic [PRICE_BITS:0]                  mid_twice_i,
  input  logic signed [qlp_pkg::POS_W-1:0]     position_i,
  // quote output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [qlp_pkg::LVL_IDX_W-1:0]        level_index_o,
  output logic [PRICE_BITS-1:0]                bid_quote_o,
  output logic [PRICE_BITS:0]                  ask_quote_o,
  output logic                                 last_o
);

  localparam int unsigned MW  = (PRICE_BITS > qlp_pkg::PROD_W) ? PRICE_BITS : qlp_pkg::PROD_W;
  localparam int unsigned W   = MW + 3;
  localparam int unsigned W1  = W + 1;
  localparam int unsigned AW  = PRICE_BITS + 1;
  localparam int unsigned LVW = $clog2(MAX_LEVELS + 1);
  localparam int unsigned CW  = $clog2(PRICE_BITS + 1);
  localparam logic [6:0]  LVL_MAX = 7'(MAX_LEVELS);

  // configuration registers
  logic [qlp_pkg::TICK_W-1:0] tick_q, min_spread_q, level_step_q;
  logic [qlp_pkg::LCNT_W-1:0] level_count_q;
  logic [qlp_pkg::QTY_W-1:0]  base_qty_q;

  // effective configuration
  logic [qlp_pkg::TICK_W-1:0] t_eff, step_eff;
  logic [qlp_pkg::QTY_W-1:0]  qty_eff;
  logic [qlp_pkg::LCNT_W-1:0] lc_eff;
  logic [6:0]                 lvl7;

  qlp_pkg::qlp_state_e state_q, state_d;

  // datapath registers
  logic [PRICE_BITS-1:0]            bb_q, bb_d, ba_q, ba_d;
  logic [AW-1:0]                    mtw_q, mtw_d;
  logic signed [qlp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [qlp_pkg::PROD_W-1:0]       prod_q, prod_d, ms_q, ms_d, spacing_q, spacing_d;
  logic signed [W-1:0]              btp_q, btp_d, bamt_q, bamt_d;
  logic signed [W-1:0]              tmp_q, tmp_d, thr_q, thr_d, res_q, res_d;
  logic signed [W-1:0]              half_q, half_d;
  logic signed [W-1:0]              pb_q, pb_d, pa_q, pa_d, nb_q, nb_d, na_q, na_d;
  logic [1:0]                       skew_q, skew_d;
  logic [qlp_pkg::REM_W-1:0]        rem_q, rem_d;
  logic [AW-1:0]                    div_q, div_d;
  logic [CW-1:0]                    cnt_q, cnt_d;
  logic [LVW-1:0]                   lv_q, lv_d;

  // shared add/subtract unit
  logic signed [W-1:0] alu_a, alu_b, alu_res;
  logic                alu_sub, alu_neg;
  logic signed [W:0]   alu_sum;

  // small multiplier for the tick products
  logic [qlp_pkg::TICK_W-1:0] mul_a;
  logic [qlp_pkg::PROD_W-1:0] mul_p;

  // status flags
  logic pb_nonpos, pa_nonpos, pa_over, nb_nonpos, na_over, last_lvl;

  // configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q        <= qlp_pkg::TICK_RST;
      min_spread_q  <= qlp_pkg::MIN_SPREAD_RST;
      level_step_q  <= qlp_pkg::LEVEL_STEP_RST;
      level_count_q <= qlp_pkg::LEVEL_CNT_RST;
      base_qty_q    <= qlp_pkg::BASE_QTY_RST;
    end else if (cfg_we_i) begin
      case (qlp_pkg::cfg_reg_e'(cfg_idx_i))
        qlp_pkg::REG_TICK:        tick_q        <= cfg_data_i[qlp_pkg::TICK_W-1:0];
        qlp_pkg::REG_MIN_SPREAD:  min_spread_q  <= cfg_data_i[qlp_pkg::TICK_W-1:0];
        qlp_pkg::REG_LEVEL_STEP:  level_step_q  <= cfg_data_i[qlp_pkg::TICK_W-1:0];
        qlp_pkg::REG_LEVEL_COUNT: level_count_q <= cfg_data_i[qlp_pkg::LCNT_W-1:0];
        qlp_pkg::REG_BASE_QTY:    base_qty_q    <= cfg_data_i[qlp_pkg::QTY_W-1:0];
        default: ;
      endcase
    end
  end

  // zero is treated as one; level count capped at MAX_LEVELS
  assign t_eff    = (tick_q == '0) ? qlp_pkg::TICK_W'(1) : tick_q;
  assign step_eff = (level_step_q == '0) ? qlp_pkg::TICK_W'(1) : level_step_q;
  assign qty_eff  = (base_qty_q == '0) ? qlp_pkg::QTY_W'(1) : base_qty_q;
  assign lc_eff   = (level_count_q == '0) ? qlp_pkg::LCNT_W'(1) : level_count_q;
  assign lvl7     = (7'(lc_eff) > LVL_MAX) ? LVL_MAX : 7'(lc_eff);

  // shared unit and multiplier
  assign alu_sum = alu_sub ? (W1'(alu_a) - W1'(alu_b)) : (W1'(alu_a) + W1'(alu_b));
  assign alu_res = $signed(alu_sum[W-1:0]);
  assign alu_neg = alu_sum[W];
  assign mul_a   = (state_q == qlp_pkg::ST_MUL_MS) ? min_spread_q : step_eff;
  assign mul_p   = qlp_pkg::PROD_W'(mul_a) * qlp_pkg::PROD_W'(t_eff);

  // range flags; ask beyond AW bits is out of range
  assign pb_nonpos = pb_q[W-1] || (pb_q == '0);
  assign pa_nonpos = pa_q[W-1] || (pa_q == '0);
  assign pa_over   = !pa_q[W-1] && (pa_q[W-1:AW] != '0);
  assign nb_nonpos = nb_q[W-1] || (nb_q == '0);
  assign na_over   = !na_q[W-1] && (na_q[W-1:AW] != '0);
  assign last_lvl  = ((7'(lv_q) + 7'd1) == lvl7) || nb_nonpos || na_over;

  // handshake and payload
  assign in_ready_o    = (state_q == qlp_pkg::ST_IDLE);
  assign out_valid_o   = (state_q == qlp_pkg::ST_EMIT);
  assign level_index_o = qlp_pkg::LVL_IDX_W'(lv_q);
  assign bid_quote_o   = pb_q[PRICE_BITS-1:0];
  assign ask_quote_o   = pa_q[AW-1:0];
  assign last_o        = last_lvl;

  // sequencer: next state, operand select, register updates
  always_comb begin
    state_d   = state_q;
    bb_d      = bb_q;
    ba_d      = ba_q;
    mtw_d     = mtw_q;
    pos_d     = pos_q;
    prod_d    = prod_q;
    ms_d      = ms_q;
    spacing_d = spacing_q;
    btp_d     = btp_q;
    bamt_d    = bamt_q;
    tmp_d     = tmp_q;
    thr_d     = thr_q;
    res_d     = res_q;
    half_d    = half_q;
    pb_d      = pb_q;
    pa_d      = pa_q;
    nb_d      = nb_q;
    na_d      = na_q;
    skew_d    = skew_q;
    rem_d     = rem_q;
    div_d     = div_q;
    cnt_d     = cnt_q;
    lv_d      = lv_q;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b0;

    case (state_q)
      qlp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          bb_d  = best_bid_i;
          ba_d  = best_ask_i;
          mtw_d = mid_twice_i;
          pos_d = position_i;
          // empty book gives no quotes
          if ((best_bid_i != '0) || (best_ask_i != '0)) begin
            state_d = qlp_pkg::ST_MUL_MS;
          end
        end
      end
      // min_spread*tick; bid + tick
      qlp_pkg::ST_MUL_MS: begin
        prod_d  = mul_p;
        alu_a   = W'(bb_q);
        alu_b   = W'(t_eff);
        btp_d   = alu_res;
        state_d = qlp_pkg::ST_MS_SEL;
      end
      // effective min spread, floored at two ticks; level_step*tick
      qlp_pkg::ST_MS_SEL: begin
        alu_a   = W'(prod_q);
        alu_b   = W'(t_eff) << 1;
        alu_sub = 1'b1;
        ms_d    = alu_neg ? qlp_pkg::PROD_W'({t_eff, 1'b0}) : prod_q;
        prod_d  = mul_p;
        state_d = qlp_pkg::ST_SPACE;
      end
      // ask - tick
      qlp_pkg::ST_SPACE: begin
        spacing_d = prod_q;
        alu_a     = W'(ba_q);
        alu_b     = W'(t_eff);
        alu_sub   = 1'b1;
        bamt_d    = alu_res;
        state_d   = ((bb_q != '0) && (ba_q != '0)) ? qlp_pkg::ST_MID : qlp_pkg::ST_ONE_SIDE;
      end
      // one-sided book: quote the other side one min spread away
      qlp_pkg::ST_ONE_SIDE: begin
        alu_b = W'(ms_q);
        if (bb_q != '0) begin
          alu_a = W'(bb_q);
          pb_d  = W'(bb_q);
          pa_d  = alu_res;
        end else begin
          alu_a   = W'(ba_q);
          alu_sub = 1'b1;
          pb_d    = alu_res;
          pa_d    = W'(ba_q);
        end
        state_d = qlp_pkg::ST_PRECHK;
      end
      // mid, half rounded up
      qlp_pkg::ST_MID: begin
        alu_a   = W'(mtw_q);
        alu_b   = W'(1'b1);
        res_d   = $signed(alu_sum[W:1]);
        state_d = qlp_pkg::ST_MAG;
      end
      // |position|
      qlp_pkg::ST_MAG: begin
        alu_b   = W'(pos_q);
        alu_sub = pos_q[qlp_pkg::POS_W-1];
        tmp_d   = alu_res;
        state_d = qlp_pkg::ST_SK1;
      end
      // skew >= k when |pos| >= (4k-2)*qty
      qlp_pkg::ST_SK1: begin
        alu_a   = tmp_q;
        alu_b   = W'(qty_eff) << 1;
        alu_sub = 1'b1;
        skew_d  = alu_neg ? 2'd0 : 2'd1;
        state_d = qlp_pkg::ST_SK2;
      end
      qlp_pkg::ST_SK2: begin
        alu_a   = W'(qty_eff) << 2;
        alu_b   = W'(qty_eff) << 1;
        thr_d   = alu_res;
        state_d = qlp_pkg::ST_SK3;
      end
      qlp_pkg::ST_SK3: begin
        alu_a   = tmp_q;
        alu_b   = thr_q;
        alu_sub = 1'b1;
        if (!alu_neg) begin
          skew_d = 2'd2;
        end
        state_d = qlp_pkg::ST_SK4;
      end
      qlp_pkg::ST_SK4: begin
        alu_a   = W'(qty_eff) << 3;
        alu_b   = W'(qty_eff) << 1;
        thr_d   = alu_res;
        state_d = qlp_pkg::ST_SK5;
      end
      qlp_pkg::ST_SK5: begin
        alu_a   = tmp_q;
        alu_b   = thr_q;
        alu_sub = 1'b1;
        if (!alu_neg) begin
          skew_d = 2'd3;
        end
        state_d = qlp_pkg::ST_SKEW_T;
      end
      // skew * tick
      qlp_pkg::ST_SKEW_T: begin
        alu_a   = skew_q[1] ? (W'(t_eff) << 1) : '0;
        alu_b   = skew_q[0] ? W'(t_eff) : '0;
        thr_d   = alu_res;
        state_d = qlp_pkg::ST_RES;
      end
      // reservation price; long moves it down
      qlp_pkg::ST_RES: begin
        alu_a   = res_q;
        alu_b   = thr_q;
        alu_sub = !pos_q[qlp_pkg::POS_W-1];
        res_d   = alu_res;
        state_d = qlp_pkg::ST_HALF;
      end
      qlp_pkg::ST_HALF: begin
        alu_a   = W'(ms_q[qlp_pkg::PROD_W-1:1]);
        alu_b   = W'(t_eff);
        alu_sub = 1'b1;
        half_d  = alu_neg ? W'(t_eff) : W'(ms_q[qlp_pkg::PROD_W-1:1]);
        state_d = qlp_pkg::ST_WIDTH;
      end
      qlp_pkg::ST_WIDTH: begin
        alu_a   = W'(ba_q);
        alu_b   = W'(bb_q);
        alu_sub = 1'b1;
        tmp_d   = alu_res;
        state_d = qlp_pkg::ST_WCMP;
      end
      // spread wider than min spread: tighten inside it
      qlp_pkg::ST_WCMP: begin
        alu_a   = W'(ms_q);
        alu_b   = tmp_q;
        alu_sub = 1'b1;
        if (alu_neg) begin
          state_d = qlp_pkg::ST_PB_LO;
        end else begin
          pb_d    = W'(bb_q);
          pa_d    = W'(ba_q);
          state_d = qlp_pkg::ST_CLAMP_B;
        end
      end
      qlp_pkg::ST_PB_LO: begin
        alu_a   = res_q;
        alu_b   = half_q;
        alu_sub = 1'b1;
        tmp_d   = alu_res;
        state_d = qlp_pkg::ST_PB_SEL;
      end
      qlp_pkg::ST_PB_SEL: begin
        alu_a   = btp_q;
        alu_b   = tmp_q;
        alu_sub = 1'b1;
        pb_d    = alu_neg ? tmp_q : btp_q;
        state_d = qlp_pkg::ST_PA_HI;
      end
      qlp_pkg::ST_PA_HI: begin
        alu_a   = res_q;
        alu_b   = half_q;
        tmp_d   = alu_res;
        state_d = qlp_pkg::ST_PA_SEL;
      end
      qlp_pkg::ST_PA_SEL: begin
        alu_a   = bamt_q;
        alu_b   = tmp_q;
        alu_sub = 1'b1;
        pa_d    = alu_neg ? bamt_q : tmp_q;
        state_d = qlp_pkg::ST_CLAMP_B;
      end
      // keep bid at most ask-tick and ask at least bid+tick
      qlp_pkg::ST_CLAMP_B: begin
        alu_a   = pb_q;
        alu_b   = bamt_q;
        alu_sub = 1'b1;
        if (!alu_neg) begin
          pb_d = bamt_q;
        end
        state_d = qlp_pkg::ST_CLAMP_A;
      end
      qlp_pkg::ST_CLAMP_A: begin
        alu_a   = pa_q;
        alu_b   = btp_q;
        alu_sub = 1'b1;
        if (alu_neg) begin
          pa_d = btp_q;
        end
        state_d = qlp_pkg::ST_PRECHK;
      end
      // reject early: rounding cannot rescue these
      qlp_pkg::ST_PRECHK: begin
        if (pb_nonpos || pa_nonpos || pa_over) begin
          state_d = qlp_pkg::ST_IDLE;
        end else begin
          div_d   = pb_q[AW-1:0];
          rem_d   = '0;
          cnt_d   = CW'(PRICE_BITS);
          state_d = qlp_pkg::ST_DIV_B;
        end
      end
      // restoring remainder by tick, one dividend bit a cycle
      qlp_pkg::ST_DIV_B, qlp_pkg::ST_DIV_A: begin
        alu_a   = W'({rem_q, div_q[AW-1]});
        alu_b   = W'(t_eff);
        alu_sub = 1'b1;
        rem_d   = alu_neg ? {rem_q[qlp_pkg::REM_W-2:0], div_q[AW-1]}
                          : alu_res[qlp_pkg::REM_W-1:0];
        div_d   = div_q << 1;
        cnt_d   = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = (state_q == qlp_pkg::ST_DIV_B) ? qlp_pkg::ST_FIX_B : qlp_pkg::ST_FIX_A1;
        end
      end
      // bid rounded down to the tick
      qlp_pkg::ST_FIX_B: begin
        alu_a   = pb_q;
        alu_b   = W'(rem_q);
        alu_sub = 1'b1;
        pb_d    = alu_res;
        div_d   = pa_q[AW-1:0];
        rem_d   = '0;
        cnt_d   = CW'(PRICE_BITS);
        state_d = qlp_pkg::ST_DIV_A;
      end
      // ask rounded up to the tick
      qlp_pkg::ST_FIX_A1: begin
        alu_a   = W'(t_eff);
        alu_b   = W'(rem_q);
        alu_sub = 1'b1;
        tmp_d   = alu_res;
        state_d = qlp_pkg::ST_FIX_A2;
      end
      qlp_pkg::ST_FIX_A2: begin
        alu_a   = pa_q;
        alu_b   = (rem_q == '0) ? '0 : tmp_q;
        pa_d    = alu_res;
        state_d = qlp_pkg::ST_CHECK;
      end
      // primary pair must be positive, uncrossed and in range
      qlp_pkg::ST_CHECK: begin
        alu_a   = pb_q;
        alu_b   = pa_q;
        alu_sub = 1'b1;
        if (pb_nonpos || pa_over || !alu_neg) begin
          state_d = qlp_pkg::ST_IDLE;
        end else begin
          lv_d    = '0;
          state_d = qlp_pkg::ST_NEXT_B;
        end
      end
      // look one level ahead to know whether this one is last
      qlp_pkg::ST_NEXT_B: begin
        alu_a   = pb_q;
        alu_b   = W'(spacing_q);
        alu_sub = 1'b1;
        nb_d    = alu_res;
        state_d = qlp_pkg::ST_NEXT_A;
      end
      qlp_pkg::ST_NEXT_A: begin
        alu_a   = pa_q;
        alu_b   = W'(spacing_q);
        na_d    = alu_res;
        state_d = qlp_pkg::ST_EMIT;
      end
      qlp_pkg::ST_EMIT: begin
        if (out_ready_i) begin
          if (last_lvl) begin
            state_d = qlp_pkg::ST_IDLE;
          end else begin
            pb_d    = nb_q;
            pa_d    = na_q;
            lv_d    = lv_q + LVW'(1);
            state_d = qlp_pkg::ST_NEXT_B;
          end
        end
      end
      default: begin
        state_d = qlp_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qlp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    bb_q      <= bb_d;
    ba_q      <= ba_d;
    mtw_q     <= mtw_d;
    pos_q     <= pos_d;
    prod_q    <= prod_d;
    ms_q      <= ms_d;
    spacing_q <= spacing_d;
    btp_q     <= btp_d;
    bamt_q    <= bamt_d;
    tmp_q     <= tmp_d;
    thr_q     <= thr_d;
    res_q     <= res_d;
    half_q    <= half_d;
    pb_q      <= pb_d;
    pa_q      <= pa_d;
    nb_q      <= nb_d;
    na_q      <= na_d;
    skew_q    <= skew_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    cnt_q     <= cnt_d;
    lv_q      <= lv_d;
  end

  // checks
  `QLP_ASSERT_IMP(a_rdy_excl, out_valid_o, !in_ready_o, "input ready while a beat is pending")
  `QLP_ASSERT_IMP(a_quote_ok, out_valid_o, (bid_quote_o != '0) && (bid_quote_o < ask_quote_o), "crossed or zero quote on output")
  `QLP_ASSERT_NXT(a_last_idle, out_valid_o && out_ready_i && last_o, in_ready_o, "not idle after last beat")

endmodule
